// ----- rtl/ctht_pkg.sv -----
// shared types, codes and defaults of the connection table handshake unit
`default_nettype none

package ctht_pkg;

    // default table size and sequence modulus
    localparam int              DEF_NUM_SLOTS   = 16;
    localparam longint unsigned DEF_SEQ_MODULUS = 64'd65536;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int PORT_W  = 16;
    localparam int STYPE_W = 2;
    localparam int SEQ_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CST_W   = 2;

    // channel widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    // command codes
    localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LISTEN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEGMENT = 2'd3;

    // segment types
    localparam logic [STYPE_W-1:0] SEG_SYN = 2'd0;
    localparam logic [STYPE_W-1:0] SEG_FIN = 2'd1;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOMATCH = 2'd2;

    // connection states
    localparam logic [CST_W-1:0] CS_CLOSED = 2'd0;
    localparam logic [CST_W-1:0] CS_LISTEN = 2'd1;
    localparam logic [CST_W-1:0] CS_CONN   = 2'd2;
    localparam logic [CST_W-1:0] CS_CLWAIT = 2'd3;

    // reply types
    localparam logic REPLY_SYNACK = 1'b0;
    localparam logic REPLY_FINACK = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } ctht_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic exec;
    } ctht_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic ack_ready;
    } ctht_stat_t;

endpackage

`default_nettype wire

// ----- rtl/connection_table_handshake_unit.sv -----
// top level of the server connection table with SYN/FIN handshake responder
//
// One request channel (s_) and one result channel (m_), stream handshake:
// a request or result moves on a rising aclk edge with tvalid and tready high.
// s_tuser carries the command (open, listen, close, incoming segment); s_tdata
// carries slot, server port, segment type, source and destination port and
// sequence number. Every request gives exactly one result on m_tdata: status,
// slot, slot state and the SYNACK/FINACK reply fields.
// The result is registered: a lookup step over the slot ports and valid bits
// fills the lookup registers, then an update step writes the output register.
// A new request is taken only once the previous one has been through both
// steps, so requests never overlap. With a sequence modulus that is not a power
// of two, the lookup step of a segment waits for the four-step reciprocal
// reduction of the ack before the update step runs.
// Reset (aresetn low, synchronous) empties the table at once through the slot
// valid bits; there is no clearing pass. A stalled result waits in the output
// register; a new request is taken once that register is free or being read.
`default_nettype none

module connection_table_handshake_unit #(
    parameter int              NUM_SLOTS   = ctht_pkg::DEF_NUM_SLOTS,
    parameter longint unsigned SEQ_MODULUS = ctht_pkg::DEF_SEQ_MODULUS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[1:0]
    input  wire logic [ctht_pkg::CMD_W-1:0]     s_tuser,
    // slot[3:0], local_port[19:4], seg_type[21:20], seg_src_port[37:22],
    // seg_dest_port[53:38], seg_seq[85:54], zero[87:86]
    input  wire logic [ctht_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status[1:0], slot_out[5:2], slot_state[7:6], reply_valid[8],
    // reply_type[9], reply_src_port[25:10], reply_dest_port[41:26],
    // reply_ack[73:42], zero[79:74]
    output logic      [ctht_pkg::M_TDATA_W-1:0] m_tdata
);

    ctht_pkg::ctht_cmd_t  cmd;
    ctht_pkg::ctht_stat_t stat;

    ctht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ctht_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/ctht_ackmod.sv -----
// reduction of the incremented sequence number modulo the sequence modulus
`default_nettype none

module ctht_ackmod #(
    parameter longint unsigned SEQ_MODULUS = ctht_pkg::DEF_SEQ_MODULUS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ctht_pkg::SEQ_W:0]    seq_inc,
    output logic      [ctht_pkg::SEQ_W-1:0]  ack,
    output logic                             ready
);

    localparam int SW = ctht_pkg::SEQ_W;

    generate
        if ((SEQ_MODULUS & (SEQ_MODULUS - 64'd1)) == 64'd0) begin : g_pow2
            // power of two: the remainder is a mask
            localparam logic [SW-1:0] MASK = SW'(SEQ_MODULUS - 64'd1);
            logic [SW-1:0] ack_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    ack_reg <= '0;
                end else if (start) begin
                    ack_reg <= seq_inc[SW-1:0] & MASK;
                end
            end

            assign ack   = ack_reg;
            assign ready = 1'b1;
        end else begin : g_recip
            // quotient by reciprocal multiplication, remainder by back-multiply
            localparam int              LOG_M = $clog2(SEQ_MODULUS);
            localparam int              SHIFT = SW + LOG_M;
            localparam longint unsigned RECIP =
                ((64'hFFFF_FFFF_FFFF_FFFF >> (64 - SHIFT)) / SEQ_MODULUS) + 64'd1;
            localparam logic [SW-1:0]   RECIP_LO = SW'(RECIP);
            localparam logic            RECIP_HI = 1'((RECIP >> SW) & 64'd1);
            localparam logic [SW-1:0]   MOD_W    = SW'(SEQ_MODULUS);
            // remainder of a sequence number that wrapped to two to the 32
            localparam logic [SW-1:0]   WRAP_REM = SW'((64'd1 << SW) % SEQ_MODULUS);

            // reduction steps
            localparam logic [1:0] STEP_MUL  = 2'd0;
            localparam logic [1:0] STEP_QUOT = 2'd1;
            localparam logic [1:0] STEP_BACK = 2'd2;
            localparam logic [1:0] STEP_SUB  = 2'd3;

            logic [SW-1:0]   x_reg;
            logic            wrap_reg;
            logic [2*SW-1:0] prod_reg;
            logic [SW-1:0]   q_reg;
            logic [SW-1:0]   qm_reg;
            logic [SW-1:0]   rem_reg;
            logic [1:0]      step_reg;
            logic            busy_reg;
            logic [2*SW-1:0] prod_full;
            logic [2*SW:0]   prod_sum;
            logic [2*SW:0]   q_full;
            logic [2*SW-1:0] qm_full;

            always_comb begin
                prod_full = x_reg * RECIP_LO;
                prod_sum  = {1'b0, prod_reg} +
                            (RECIP_HI ? {1'b0, x_reg, {SW{1'b0}}} : {(2*SW+1){1'b0}});
                q_full    = prod_sum >> SHIFT;
                qm_full   = q_reg * MOD_W;
            end

            // step counter
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    step_reg <= STEP_MUL;
                end else if (start) begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_MUL;
                end else if (busy_reg) begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == STEP_SUB) begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            // datapath of the reduction
            always_ff @(posedge aclk) begin
                if (start) begin
                    x_reg    <= seq_inc[SW-1:0];
                    wrap_reg <= seq_inc[SW];
                end
                if (busy_reg) begin
                    case (step_reg)
                        STEP_MUL: begin
                            prod_reg <= prod_full;
                        end
                        STEP_QUOT: begin
                            q_reg <= q_full[SW-1:0];
                        end
                        STEP_BACK: begin
                            qm_reg <= qm_full[SW-1:0];
                        end
                        STEP_SUB: begin
                            rem_reg <= wrap_reg ? WRAP_REM : (x_reg - qm_reg);
                        end
                        default: begin
                        end
                    endcase
                end
            end

            assign ack   = rem_reg;
            assign ready = !busy_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ----- rtl/ctht_ctrl.sv -----
// controller state machine of the connection table handshake unit
`default_nettype none

module ctht_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire ctht_pkg::ctht_stat_t stat,
    output ctht_pkg::ctht_cmd_t       cmd
);

    ctht_pkg::ctht_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctht_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.lookup  = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ctht_pkg::ST_IDLE: begin
                s_tready    = stat.out_free;
                cmd.capture = s_tvalid && stat.out_free;
                if (cmd.capture) begin
                    state_next = ctht_pkg::ST_LOOKUP;
                end
            end
            ctht_pkg::ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                if (stat.ack_ready) begin
                    state_next = ctht_pkg::ST_EXEC;
                end
            end
            ctht_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ctht_pkg::ST_IDLE;
            end
            default: begin
                state_next = ctht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ctht_datapath.sv -----
// slot table, lookup, update and result register of the handshake unit
`default_nettype none

module ctht_datapath #(
    parameter int              NUM_SLOTS   = ctht_pkg::DEF_NUM_SLOTS,
    parameter longint unsigned SEQ_MODULUS = ctht_pkg::DEF_SEQ_MODULUS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ctht_pkg::ctht_cmd_t                cmd,
    output ctht_pkg::ctht_stat_t                    stat,
    input  wire logic [ctht_pkg::CMD_W-1:0]         s_tuser,
    input  wire logic [ctht_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic      [ctht_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW     = ctht_pkg::PORT_W;
    localparam int SW     = ctht_pkg::SEQ_W;
    localparam int OUT_W  = 74;

    // captured request
    logic [ctht_pkg::CMD_W-1:0]   cmd_reg;
    logic [ctht_pkg::SLOT_W-1:0]  slot_reg;
    logic [PW-1:0]                lport_reg;
    logic [ctht_pkg::STYPE_W-1:0] stype_reg;
    logic [PW-1:0]                sport_reg;
    logic [PW-1:0]                dport_reg;

    // slot table
    logic [NUM_SLOTS-1:0]         used_reg;
    logic [PW-1:0]                sp_reg    [NUM_SLOTS];
    logic [ctht_pkg::CST_W-1:0]   conn_mem  [NUM_SLOTS];
    logic [PW-1:0]                cport_mem [NUM_SLOTS];
    logic [SW-1:0]                eseq_mem  [NUM_SLOTS];

    // lookup results
    logic [IDX_W-1:0]             idx_reg;
    logic                         hit_reg;
    logic [ctht_pkg::CST_W-1:0]   conn_rd_reg;
    logic [PW-1:0]                cport_rd_reg;

    // output register
    logic                         m_valid_reg;
    logic [OUT_W-1:0]             out_reg;

    // ack unit
    logic [SW:0]                  seq_inc;
    logic [SW-1:0]                ack;
    logic                         ack_ready;
    logic                         ack_start;

    assign seq_inc   = {1'b0, s_tdata[85:54]} + {{SW{1'b0}}, 1'b1};
    assign ack_start = cmd.capture && (s_tuser == ctht_pkg::CMD_SEGMENT);

    ctht_ackmod #(
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_ackmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ack_start),
        .seq_inc (seq_inc),
        .ack     (ack),
        .ready   (ack_ready)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_tuser;
            slot_reg  <= s_tdata[3:0];
            lport_reg <= s_tdata[19:4];
            stype_reg <= s_tdata[21:20];
            sport_reg <= s_tdata[37:22];
            dport_reg <= s_tdata[53:38];
        end
    end

    // lowest free or port-matching slot, or the addressed slot
    logic [NUM_SLOTS-1:0] sel_vec;
    logic [IDX_W-1:0]     enc_idx;
    logic                 enc_hit;
    logic                 slot_in_range;
    logic [IDX_W-1:0]     slot_idx;
    logic [IDX_W-1:0]     lk_idx;
    logic                 lk_hit;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (cmd_reg == ctht_pkg::CMD_OPEN) begin
                sel_vec[i] = !used_reg[i];
            end else begin
                sel_vec[i] = used_reg[i] && (sp_reg[i] == dport_reg);
            end
        end
        enc_idx = '0;
        enc_hit = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (sel_vec[i]) begin
                enc_idx = IDX_W'(i);
                enc_hit = 1'b1;
            end
        end
        slot_in_range = int'(slot_reg) < NUM_SLOTS;
        slot_idx      = IDX_W'(slot_reg);
        if ((cmd_reg == ctht_pkg::CMD_LISTEN) || (cmd_reg == ctht_pkg::CMD_CLOSE)) begin
            lk_idx = slot_idx;
            lk_hit = slot_in_range && used_reg[slot_idx];
        end else begin
            lk_idx = enc_idx;
            lk_hit = enc_hit;
        end
    end

    // lookup registers and memory reads
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            idx_reg      <= lk_idx;
            hit_reg      <= lk_hit;
            conn_rd_reg  <= conn_mem[lk_idx];
            cport_rd_reg <= cport_mem[lk_idx];
        end
    end

    // command execution
    logic [ctht_pkg::STAT_W-1:0] r_status;
    logic [ctht_pkg::SLOT_W-1:0] r_slot;
    logic [ctht_pkg::CST_W-1:0]  r_state;
    logic                        r_valid;
    logic                        r_type;
    logic [PW-1:0]               r_src;
    logic [PW-1:0]               r_dst;
    logic [SW-1:0]               r_ack;
    logic                        used_set;
    logic                        used_clr;
    logic                        sp_we;
    logic                        conn_we;
    logic [ctht_pkg::CST_W-1:0]  conn_wd;
    logic                        cport_we;
    logic                        eseq_we;
    logic [SW-1:0]               eseq_wd;
    logic                        syn_ok;
    logic                        fin_ok;

    always_comb begin
        r_status = ctht_pkg::STATUS_OK;
        r_slot   = '0;
        r_state  = ctht_pkg::CS_CLOSED;
        r_valid  = 1'b0;
        r_type   = ctht_pkg::REPLY_SYNACK;
        r_src    = '0;
        r_dst    = '0;
        r_ack    = '0;
        used_set = 1'b0;
        used_clr = 1'b0;
        sp_we    = 1'b0;
        conn_we  = 1'b0;
        conn_wd  = ctht_pkg::CS_CLOSED;
        cport_we = 1'b0;
        eseq_we  = 1'b0;
        eseq_wd  = '0;
        syn_ok   = (stype_reg == ctht_pkg::SEG_SYN) &&
                   ((conn_rd_reg == ctht_pkg::CS_LISTEN) || (conn_rd_reg == ctht_pkg::CS_CONN));
        fin_ok   = (stype_reg == ctht_pkg::SEG_FIN) &&
                   ((conn_rd_reg == ctht_pkg::CS_CONN) || (conn_rd_reg == ctht_pkg::CS_CLWAIT));
        case (cmd_reg)
            ctht_pkg::CMD_OPEN: begin
                if (!hit_reg) begin
                    r_status = ctht_pkg::STATUS_REFUSED;
                end else begin
                    r_slot   = ctht_pkg::SLOT_W'(idx_reg);
                    used_set = 1'b1;
                    sp_we    = 1'b1;
                    conn_we  = 1'b1;
                    conn_wd  = ctht_pkg::CS_CLOSED;
                    eseq_we  = 1'b1;
                end
            end
            ctht_pkg::CMD_LISTEN: begin
                r_slot = slot_reg;
                if (!hit_reg) begin
                    r_status = ctht_pkg::STATUS_REFUSED;
                end else begin
                    conn_we = 1'b1;
                    conn_wd = ctht_pkg::CS_LISTEN;
                    r_state = ctht_pkg::CS_LISTEN;
                end
            end
            ctht_pkg::CMD_CLOSE: begin
                r_slot = slot_reg;
                if (!hit_reg) begin
                    r_status = ctht_pkg::STATUS_REFUSED;
                end else if ((conn_rd_reg == ctht_pkg::CS_CLOSED) ||
                             (conn_rd_reg == ctht_pkg::CS_CLWAIT)) begin
                    used_clr = 1'b1;
                end else begin
                    r_status = ctht_pkg::STATUS_REFUSED;
                    r_state  = conn_rd_reg;
                end
            end
            ctht_pkg::CMD_SEGMENT: begin
                if (!hit_reg) begin
                    r_status = ctht_pkg::STATUS_NOMATCH;
                end else begin
                    r_slot  = ctht_pkg::SLOT_W'(idx_reg);
                    r_state = conn_rd_reg;
                    if (syn_ok || fin_ok) begin
                        conn_we = 1'b1;
                        eseq_we = 1'b1;
                        eseq_wd = ack;
                        r_valid = 1'b1;
                        r_src   = dport_reg;
                        r_ack   = ack;
                        if (syn_ok) begin
                            // client port is taken from this segment
                            cport_we = 1'b1;
                            conn_wd  = ctht_pkg::CS_CONN;
                            r_type   = ctht_pkg::REPLY_SYNACK;
                            r_dst    = sport_reg;
                        end else begin
                            conn_wd = ctht_pkg::CS_CLWAIT;
                            r_type  = ctht_pkg::REPLY_FINACK;
                            r_dst   = cport_rd_reg;
                        end
                        r_state = conn_wd;
                    end
                end
            end
            default: begin
                r_status = ctht_pkg::STATUS_REFUSED;
            end
        endcase
    end

    // slot valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (cmd.exec) begin
            if (used_set) begin
                used_reg[idx_reg] <= 1'b1;
            end else if (used_clr) begin
                used_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // table writes
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (sp_we) begin
                sp_reg[idx_reg] <= lport_reg;
            end
            if (conn_we) begin
                conn_mem[idx_reg] <= conn_wd;
            end
            if (cport_we) begin
                cport_mem[idx_reg] <= sport_reg;
            end
            if (eseq_we) begin
                eseq_mem[idx_reg] <= eseq_wd;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg <= {r_ack, r_dst, r_src, r_type, r_valid, r_state, r_slot, r_status};
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = {{(ctht_pkg::M_TDATA_W - OUT_W){1'b0}}, out_reg};
    assign stat.out_free  = !m_valid_reg || m_tready;
    assign stat.ack_ready = ack_ready;

    // a result is only produced into an empty output register
    a_exec_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !m_valid_reg)
        else $error("result produced while output register busy");

    // a successful open marks its slot as used
    a_open_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (cmd_reg == ctht_pkg::CMD_OPEN) && hit_reg |=> used_reg[$past(idx_reg)])
        else $error("opened slot not marked used");

    // a reply is only sent with an ok status
    a_reply_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg[8] |-> (out_reg[1:0] == ctht_pkg::STATUS_OK))
        else $error("reply sent with failing status");

    // the execute step never runs before the ack is settled
    a_ack_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> $past(ack_ready))
        else $error("execute without settled ack");

endmodule

`default_nettype wire

// ----- dv/connection_table_handshake_unit_tb.sv -----
// self-checking testbench for the server connection table handshake unit
`timescale 1ns / 100ps

module connection_table_handshake_unit_tb;
    import ctht_pkg::*;

    localparam int              N_SLOTS    = DEF_NUM_SLOTS;
    localparam longint unsigned ACK_MOD    = DEF_SEQ_MODULUS;
    localparam int              N_RANDOM   = 500;
    localparam int              MAX_GAP    = 13;
    localparam int              LONG_HOLD  = 400;
    localparam int              HOLD_AT    = 60;
    localparam int              DRAIN_CYC  = 20;
    localparam int              CYCLE_CAP  = 200000;

    // segment types with no handshake meaning
    localparam logic [STYPE_W-1:0] SEG_OTHER    = 2'd2;
    localparam logic [STYPE_W-1:0] SEG_OTHER_HI = 2'd3;

    // one request as seen on the input channel
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [PORT_W-1:0]  local_port;
        logic [STYPE_W-1:0] seg_type;
        logic [PORT_W-1:0]  seg_sport;
        logic [PORT_W-1:0]  seg_dport;
        logic [SEQ_W-1:0]   seq;
    } conn_req_t;

    // one result as seen on the output channel
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot_out;
        logic [CST_W-1:0]   slot_state;
        logic               reply_valid;
        logic               reply_type;
        logic [PORT_W-1:0]  reply_src;
        logic [PORT_W-1:0]  reply_dst;
        logic [SEQ_W-1:0]   reply_ack;
    } conn_res_t;

    // connection table mirror plus the queue of results still due
    class conn_table_model;
        bit                 used [N_SLOTS];
        logic [PORT_W-1:0]  srv_port [N_SLOTS];
        logic [PORT_W-1:0]  cli_port [N_SLOTS];
        logic [CST_W-1:0]   cstate [N_SLOTS];
        logic [SEQ_W-1:0]   exp_seq [N_SLOTS];
        conn_res_t          due_results [$];
        int                 n_errors;

        function new();
            for (int i = 0; i < N_SLOTS; i++) begin
                used[i]     = 1'b0;
                srv_port[i] = '0;
                cli_port[i] = '0;
                cstate[i]   = CS_CLOSED;
                exp_seq[i]  = '0;
            end
            n_errors = 0;
        endfunction

        // apply one accepted request to the table and queue its result
        function void note_request(conn_req_t r);
            conn_res_t       e;
            int              hit;
            logic [CST_W-1:0] st;
            bit              syn_ok;
            bit              fin_ok;
            longint unsigned ack;
            e   = '0;
            hit = -1;
            case (r.cmd)
                CMD_OPEN: begin
                    for (int i = 0; i < N_SLOTS; i++)
                        if (!used[i] && hit < 0) hit = i;
                    if (hit < 0) begin
                        e.status = STATUS_REFUSED;
                    end else begin
                        used[hit]     = 1'b1;
                        srv_port[hit] = r.local_port;
                        cstate[hit]   = CS_CLOSED;
                        exp_seq[hit]  = '0;
                        e.slot_out    = SLOT_W'(hit);
                        e.slot_state  = CS_CLOSED;
                    end
                end
                CMD_LISTEN, CMD_CLOSE: begin
                    e.slot_out = r.slot;
                    if (!used[r.slot]) begin
                        e.status = STATUS_REFUSED;
                    end else if (r.cmd == CMD_LISTEN) begin
                        cstate[r.slot] = CS_LISTEN;
                        e.slot_state   = CS_LISTEN;
                    end else if (cstate[r.slot] == CS_CLOSED ||
                                 cstate[r.slot] == CS_CLWAIT) begin
                        used[r.slot] = 1'b0;
                    end else begin
                        e.status     = STATUS_REFUSED;
                        e.slot_state = cstate[r.slot];
                    end
                end
                default: begin
                    // incoming segment: lowest live slot with matching server port
                    for (int i = 0; i < N_SLOTS; i++)
                        if (used[i] && srv_port[i] == r.seg_dport && hit < 0) hit = i;
                    if (hit < 0) begin
                        e.status = STATUS_NOMATCH;
                    end else begin
                        st         = cstate[hit];
                        syn_ok     = (r.seg_type == SEG_SYN) &&
                                     (st == CS_LISTEN || st == CS_CONN);
                        fin_ok     = (r.seg_type == SEG_FIN) &&
                                     (st == CS_CONN || st == CS_CLWAIT);
                        e.slot_out = SLOT_W'(hit);
                        if (syn_ok || fin_ok) begin
                            ack = (longint'(r.seq) + 1) % ACK_MOD;
                            if (syn_ok) begin
                                cli_port[hit] = r.seg_sport;
                                cstate[hit]   = CS_CONN;
                                e.reply_type  = REPLY_SYNACK;
                            end else begin
                                cstate[hit]   = CS_CLWAIT;
                                e.reply_type  = REPLY_FINACK;
                            end
                            exp_seq[hit]  = ack[SEQ_W-1:0];
                            e.reply_valid = 1'b1;
                            e.reply_src   = srv_port[hit];
                            e.reply_dst   = cli_port[hit];
                            e.reply_ack   = ack[SEQ_W-1:0];
                        end
                        e.slot_state = cstate[hit];
                    end
                end
            endcase
            due_results.push_back(e);
        endfunction

        function void cmp(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                n_errors++;
            end
        endfunction

        // compare one accepted result with the oldest one due
        function void check_result(logic [M_TDATA_W-1:0] d);
            conn_res_t e;
            if (due_results.size() == 0) begin
                $error("result %0h arrived with none due", d);
                n_errors++;
            end else begin
                e = due_results.pop_front();
                cmp("status", e.status, d[1:0]);
                cmp("slot_out", e.slot_out, d[5:2]);
                cmp("slot_state", e.slot_state, d[7:6]);
                cmp("reply_valid", e.reply_valid, d[8]);
                cmp("reply_type", e.reply_type, d[9]);
                cmp("reply_src_port", e.reply_src, d[25:10]);
                cmp("reply_dest_port", e.reply_dst, d[41:26]);
                cmp("reply_ack", e.reply_ack, d[73:42]);
                cmp("pad", 0, d[79:74]);
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    conn_table_model       sb = new();
    bit                    quiet = 1'b0;
    int                    n_results = 0;
    int                    cyc = 0;
    logic [PORT_W-1:0]     port_pool [6];

    connection_table_handshake_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic conn_req_t build_request(
        logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot, logic [PORT_W-1:0] lport,
        logic [STYPE_W-1:0] stype, logic [PORT_W-1:0] src, logic [PORT_W-1:0] dst,
        logic [SEQ_W-1:0] seq);
        conn_req_t r;
        r.cmd        = cmd;
        r.slot       = slot;
        r.local_port = lport;
        r.seg_type   = stype;
        r.seg_sport  = src;
        r.seg_dport  = dst;
        r.seq        = seq;
        return r;
    endfunction

    // mostly well-formed requests aimed at live slots and known ports
    function automatic conn_req_t make_random_request();
        conn_req_t r;
        int        pick;
        int        live [$];
        r.slot       = SLOT_W'($urandom);
        r.local_port = PORT_W'($urandom);
        r.seg_type   = STYPE_W'($urandom);
        r.seg_sport  = PORT_W'($urandom);
        r.seg_dport  = PORT_W'($urandom);
        r.seq        = SEQ_W'($urandom);
        for (int i = 0; i < N_SLOTS; i++)
            if (sb.used[i]) live.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 22)      r.cmd = CMD_OPEN;
        else if (pick < 37) r.cmd = CMD_LISTEN;
        else if (pick < 52) r.cmd = CMD_CLOSE;
        else                r.cmd = CMD_SEGMENT;
        if (r.cmd == CMD_OPEN && $urandom_range(0, 9) < 8)
            r.local_port = port_pool[$urandom_range(0, 5)];
        if ((r.cmd == CMD_LISTEN || r.cmd == CMD_CLOSE) && live.size() > 0 &&
            $urandom_range(0, 9) < 8)
            r.slot = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
        if (r.cmd == CMD_SEGMENT) begin
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
                r.seg_dport = sb.srv_port[live[$urandom_range(0, live.size() - 1)]];
            pick = $urandom_range(0, 9);
            if (pick < 4)      r.seg_type = SEG_SYN;
            else if (pick < 8) r.seg_type = SEG_FIN;
            else               r.seg_type = $urandom_range(0, 1) ? SEG_OTHER_HI : SEG_OTHER;
            // sequence numbers at the wrap points now and then
            case ($urandom_range(0, 19))
                0:       r.seq = '1;
                1:       r.seq = 32'h0000_FFFF;
                2:       r.seq = '0;
                default: ;
            endcase
        end
        return r;
    endfunction

    // offer one request and note it when the block takes it
    task automatic send_request(conn_req_t r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= {2'b00, r.seq, r.seg_dport, r.seg_sport, r.seg_type, r.local_port,
                     r.slot};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    // result side: random stalls, one long hold to back the block up
    initial begin : result_sink
        int  hold;
        bit  held;
        hold = 0;
        held = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            @(posedge aclk);
            if (m_tready && m_tvalid) begin
                sb.check_result(m_tdata);
                n_results++;
                hold = draw_gap();
                if (!held && n_results >= HOLD_AT) begin
                    hold = LONG_HOLD;
                    held = 1'b1;
                end
                if (hold > 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (hold > 0) hold--;
                if (hold == 0) m_tready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cyc < CYCLE_CAP) begin
            @(posedge aclk);
            cyc++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        port_pool[0] = '0;
        port_pool[1] = '1;
        for (int i = 2; i < 6; i++) port_pool[i] = PORT_W'($urandom);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: refusals on an empty table, no match
        send_request(build_request(CMD_CLOSE, 4'd0, '0, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_LISTEN, 4'd15, '1, SEG_SYN, '1, '1, '1));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, '0, '0, '0));
        // opens at port extremes, duplicate port
        send_request(build_request(CMD_OPEN, 4'd0, 16'h0000, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_OPEN, 4'd0, 16'hFFFF, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_OPEN, 4'd0, 16'h0000, SEG_SYN, '0, '0, '0));
        // syn on a closed slot is ignored
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, 16'h1111, 16'h0000, 32'd5));
        send_request(build_request(CMD_LISTEN, 4'd0, '0, SEG_SYN, '0, '0, '0));
        // synack with ack wrap, then a repeated syn while connected
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, 16'hFFFF, 16'h0000, '1));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, 16'h1234, 16'h0000, '0));
        // close while connected is refused
        send_request(build_request(CMD_CLOSE, 4'd0, '0, SEG_SYN, '0, '0, '0));
        // finack, then again in close-wait
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_FIN, 16'h0001, 16'h0000,
                                   32'h0000_FFFE));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_FIN, 16'h0002, 16'h0000,
                                   32'h0000_FFFF));
        // segments that do nothing
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, '0, 16'h0000, 32'd9));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_OTHER, '0, 16'hFFFF, '1));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_OTHER_HI, '0, 16'h0000, '1));
        // listen from close-wait, fin while listening, close refused
        send_request(build_request(CMD_LISTEN, 4'd0, '0, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_FIN, '0, 16'h0000, 32'd3));
        send_request(build_request(CMD_CLOSE, 4'd0, '0, SEG_SYN, '0, '0, '0));
        // close a closed slot, then touch the freed slot
        send_request(build_request(CMD_CLOSE, 4'd2, '0, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_SEGMENT, 4'd0, '0, SEG_SYN, 16'h4321, 16'h0000, 32'd7));
        send_request(build_request(CMD_LISTEN, 4'd2, '0, SEG_SYN, '0, '0, '0));
        send_request(build_request(CMD_OPEN, 4'd9, 16'h8000, SEG_FIN, '1, '1, '1));

        // random part, idle mode redrawn in stretches
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_request(make_random_request());
        end
        s_tvalid <= 1'b0;

        while (sb.due_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (sb.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ctht_pkg.sv
rtl/ctht_ackmod.sv
rtl/ctht_ctrl.sv
rtl/ctht_datapath.sv
rtl/connection_table_handshake_unit.sv
dv/connection_table_handshake_unit_tb.sv
